FILE: sv/ncaa_pkg.sv
// ----------------------------------------------------------------------------
// ncaa_pkg: shared types and constants
// Function codes and field widths for the nearest-center assignment core.
// ----------------------------------------------------------------------------
`default_nettype none
package ncaa_pkg;
    localparam int BAND_W   = 8;
    localparam int SUM_W    = 28;
    localparam int DIST_W   = 18;
    localparam int FIELD_B  = 4;
    localparam int LABEL_W  = 4;
    localparam int OUTCNT_W = 20;

    typedef enum logic [1:0] {
        FUNC_LOAD     = 2'd0,
        FUNC_CLASSIFY = 2'd1,
        FUNC_READ     = 2'd2,
        FUNC_CLEAR    = 2'd3
    } func_t;

    localparam logic CFG_NUM_CLUSTERS = 1'b0;
    localparam logic CFG_ACTIVE_BANDS = 1'b1;
endpackage
`default_nettype wire

FILE: sv/nearest_center_assign_accumulate_core.sv
// ----------------------------------------------------------------------------
// nearest_center_assign_accumulate_core
// Nearest-center search with per-cluster saturating count and band sums.
// ----------------------------------------------------------------------------
// Channel | Direction | Transfer condition
// s_      | in        | s_tvalid && s_tready: one load/classify/read/clear item
// m_      | out       | m_tvalid && m_tready: one result per item
// cfg_    | in        | cfg_valid && cfg_ready: register write
//
// Each item is handled one at a time by a sequencer over memories with a
// registered read. In a classify, one center row is read per cycle from the
// center memory, which sets the search rate; the winner's totals are then
// read, updated and written back. After reset and on a clear item, a pass
// clears the totals memories one cluster per cycle, during which no item
// is accepted. The center memory is swept to zero after reset in the same
// pass. The result register holds while m_tready is low; the next item is
// accepted only once the result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_center_assign_accumulate_core #(
    parameter int MAX_CLUSTERS = 16,
    parameter int BANDS        = 4,
    parameter int COUNT_BITS   = 20
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: cluster[3:0], band0[11:4], band1[19:12], band2[27:20], band3[35:28], pad
    input  wire logic [39:0]  s_tdata,
    // tuser: func[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: label[3:0], dist_sq[21:4], member_count[41:22], sum0[69:42],
    //        sum1[97:70], sum2[125:98], sum3[153:126], pad
    output logic [159:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [4:0]   cfg_data
);
    localparam int CL_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int NB_W  = $clog2(BANDS + 1);
    localparam int ROW_W = BANDS * ncaa_pkg::BAND_W;
    localparam int SROW_W = BANDS * ncaa_pkg::SUM_W;
    localparam int DACC_W = 2 * ncaa_pkg::BAND_W + 5;
    localparam int SQ_W   = 2 * ncaa_pkg::BAND_W + 2;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [ncaa_pkg::SUM_W-1:0] SUM_MAX = '1;

    typedef enum logic [6:0] {
        ST_CLR   = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_SRCH  = 7'b0000100,
        ST_SLAST = 7'b0001000,
        ST_UPD   = 7'b0010000,
        ST_RDWT  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [ROW_W-1:0]          center_mem [MAX_CLUSTERS];
    logic [COUNT_BITS-1:0]     count_mem  [MAX_CLUSTERS];
    logic [SROW_W-1:0]         sum_mem    [MAX_CLUSTERS];
    logic [ROW_W-1:0]          center_rd_reg;
    logic [COUNT_BITS-1:0]     count_rd_reg;
    logic [SROW_W-1:0]         sum_rd_reg;

    logic [4:0]                num_clusters_reg;
    logic [2:0]                active_bands_reg;
    logic                      clr_centers_reg;
    logic [CL_W-1:0]           ptr_reg;   // clear/search pointer
    logic [CL_W-1:0]           cand_reg;  // index of row in center_rd_reg
    logic [CL_W-1:0]           best_reg;
    logic [DACC_W-1:0]         best_d_reg;
    logic                      first_reg;
    logic [3:0]                cl_reg;
    logic [ROW_W-1:0]          pix_reg;
    logic [159:0]              out_reg;
    logic                      out_valid_reg;

    logic [CL_W-1:0]           nc_last;
    logic [NB_W-1:0]           nb_eff;
    logic [DACC_W-1:0]         cand_d;

    // Effective counts after clamping out-of-range register values.
    always_comb begin
        if (num_clusters_reg == '0)
            nc_last = '0;
        else if (32'(num_clusters_reg) > MAX_CLUSTERS)
            nc_last = CL_W'(MAX_CLUSTERS - 1);
        else
            nc_last = CL_W'(num_clusters_reg - 5'd1);
        if (active_bands_reg == '0)
            nb_eff = NB_W'(1);
        else if (32'(active_bands_reg) > BANDS)
            nb_eff = NB_W'(BANDS);
        else
            nb_eff = NB_W'(active_bands_reg);
    end

    // Distance of the candidate row against the held pixel.
    always_comb begin
        logic signed [ncaa_pkg::BAND_W:0] diff;
        logic signed [SQ_W-1:0] sq;
        cand_d = '0;
        for (int b = 0; b < BANDS; b++) begin
            diff = $signed({1'b0, pix_reg[b*ncaa_pkg::BAND_W +: ncaa_pkg::BAND_W]})
                 - $signed({1'b0, center_rd_reg[b*ncaa_pkg::BAND_W +: ncaa_pkg::BAND_W]});
            sq = SQ_W'(diff) * SQ_W'(diff);
            if (b < 32'(nb_eff))
                cand_d = cand_d + DACC_W'($unsigned(sq));
        end
    end

    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    logic [CL_W-1:0] s_cl;
    assign s_cl = CL_W'(s_tdata[3:0]);
    logic s_cl_ok;
    assign s_cl_ok = 32'(s_tdata[3:0]) < MAX_CLUSTERS;

    logic [ROW_W-1:0] s_row;
    always_comb begin
        for (int b = 0; b < BANDS; b++) begin
            if (b < ncaa_pkg::FIELD_B)
                s_row[b*ncaa_pkg::BAND_W +: ncaa_pkg::BAND_W] = s_tdata[4 + b*8 +: 8];
            else
                s_row[b*ncaa_pkg::BAND_W +: ncaa_pkg::BAND_W] = '0;
        end
    end

    // Read address for the center memory. On the last search cycle the
    // current row is read again so that it is still there for the final
    // compare.
    logic [CL_W-1:0] c_raddr;
    assign c_raddr = (state_reg == ST_IDLE) ? '0 :
                     (state_reg == ST_SRCH && cand_reg == nc_last) ? cand_reg : ptr_reg;

    // Winner candidate and updated totals.
    logic upd_better;
    assign upd_better = first_reg || (cand_d < best_d_reg);
    logic [CL_W-1:0] win_idx;
    logic [DACC_W-1:0] win_d;
    assign win_idx = upd_better ? cand_reg : best_reg;
    assign win_d   = upd_better ? cand_d : best_d_reg;

    logic [COUNT_BITS-1:0] cnt_new;
    logic [SROW_W-1:0]     sum_new;
    always_comb begin
        logic [ncaa_pkg::SUM_W:0] v;
        cnt_new = (count_rd_reg < COUNT_MAX) ? count_rd_reg + 1'b1 : count_rd_reg;
        sum_new = sum_rd_reg;
        for (int b = 0; b < BANDS; b++) begin
            v = {1'b0, sum_rd_reg[b*ncaa_pkg::SUM_W +: ncaa_pkg::SUM_W]}
              + (ncaa_pkg::SUM_W+1)'(pix_reg[b*ncaa_pkg::BAND_W +: ncaa_pkg::BAND_W]);
            if (b < 32'(nb_eff))
                sum_new[b*ncaa_pkg::SUM_W +: ncaa_pkg::SUM_W] =
                    v[ncaa_pkg::SUM_W] ? SUM_MAX : v[ncaa_pkg::SUM_W-1:0];
        end
    end

    // Classify result: label and saturated distance.
    logic [ncaa_pkg::DIST_W-1:0] dist_sat;
    assign dist_sat = (best_d_reg > DACC_W'({ncaa_pkg::DIST_W{1'b1}}))
                    ? '1 : ncaa_pkg::DIST_W'(best_d_reg);

    // Read result: echoed index and the totals of that cluster.
    logic [159:0] rd_word;
    always_comb begin
        rd_word = '0;
        rd_word[3:0] = cl_reg;
        if (32'(cl_reg) < MAX_CLUSTERS) begin
            rd_word[41:22] = 20'(count_rd_reg);
            for (int b = 0; b < BANDS && b < ncaa_pkg::FIELD_B; b++)
                rd_word[42 + b*28 +: 28] = sum_rd_reg[b*ncaa_pkg::SUM_W +: ncaa_pkg::SUM_W];
        end
    end

    logic [CL_W-1:0] t_raddr;
    assign t_raddr = (state_reg == ST_SLAST) ? win_idx : CL_W'(cl_reg);

    // Memories: synchronous write and registered read.
    always_ff @(posedge aclk) begin
        center_rd_reg <= center_mem[c_raddr];
        count_rd_reg  <= count_mem[t_raddr];
        sum_rd_reg    <= sum_mem[t_raddr];
        if (state_reg == ST_CLR) begin
            count_mem[ptr_reg] <= '0;
            sum_mem[ptr_reg]   <= '0;
            if (clr_centers_reg)
                center_mem[ptr_reg] <= '0;
        end else if (s_fire && s_tuser == ncaa_pkg::FUNC_LOAD && s_cl_ok) begin
            center_mem[s_cl] <= s_row;
        end else if (state_reg == ST_UPD) begin
            count_mem[best_reg] <= cnt_new;
            sum_mem[best_reg]   <= sum_new;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:   if (ptr_reg == CL_W'(MAX_CLUSTERS - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_tuser)
                        ncaa_pkg::FUNC_CLASSIFY: state_next = ST_SRCH;
                        ncaa_pkg::FUNC_READ:     state_next = ST_RDWT;
                        ncaa_pkg::FUNC_CLEAR:    state_next = ST_CLR;
                        default:                 state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SRCH:  if (cand_reg == nc_last) state_next = ST_SLAST;
            ST_SLAST: state_next = ST_UPD;
            ST_UPD:   state_next = ST_IDLE;
            ST_RDWT:  state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ST_SRCH: center_rd_reg holds row cand_reg; ptr_reg runs one ahead.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLR;
            ptr_reg          <= '0;
            clr_centers_reg  <= 1'b1;
            out_valid_reg    <= 1'b0;
            num_clusters_reg <= 5'd16;
            active_bands_reg <= 3'd4;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                if (cfg_index == ncaa_pkg::CFG_NUM_CLUSTERS)
                    num_clusters_reg <= cfg_data;
                else
                    active_bands_reg <= cfg_data[2:0];
            end
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLR: begin
                    if (ptr_reg == CL_W'(MAX_CLUSTERS - 1)) begin
                        ptr_reg         <= '0;
                        clr_centers_reg <= 1'b0;
                    end else begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        cl_reg    <= s_tdata[3:0];
                        pix_reg   <= s_row;
                        cand_reg  <= '0;
                        first_reg <= 1'b1;
                        ptr_reg   <= (s_tuser == ncaa_pkg::FUNC_CLEAR) ? '0 : CL_W'(1);
                        if (s_tuser == ncaa_pkg::FUNC_CLEAR ||
                            s_tuser == ncaa_pkg::FUNC_LOAD) begin
                            out_reg       <= '0;
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_SRCH: begin
                    if (cand_reg != nc_last) begin
                        best_reg   <= win_idx;
                        best_d_reg <= win_d;
                        first_reg  <= 1'b0;
                        cand_reg   <= ptr_reg;
                        ptr_reg    <= ptr_reg + 1'b1;
                    end
                end
                ST_SLAST: begin
                    best_reg   <= win_idx;
                    best_d_reg <= win_d;
                end
                ST_UPD: begin
                    out_reg <= {{(160 - ncaa_pkg::DIST_W - 4){1'b0}}, dist_sat, 4'(best_reg)};
                    out_valid_reg <= 1'b1;
                    ptr_reg <= '0;
                end
                ST_RDWT: ;
                ST_OUT: begin
                    out_reg       <= rd_word;
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
